@@ hw/rtl/cau_pkg.sv @@
// cau_pkg: shared types and codes for the complex arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package cau_pkg;

   localparam int DataWidth = 16;
   localparam int FracBits  = 8;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_SAT = 2'd1;
   localparam logic [1:0] STAT_DBZ = 2'd2;

   typedef struct packed {
      logic [1:0]                  kind;
      logic signed [DataWidth-1:0] a_re;
      logic signed [DataWidth-1:0] a_im;
      logic signed [DataWidth-1:0] b_re;
      logic signed [DataWidth-1:0] b_im;
   } req_word_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] res_re;
      logic signed [DataWidth-1:0] res_im;
      logic [1:0]                  status;
   } rsp_word_type;

endpackage

@@ hw/rtl/cau_div.sv @@
// cau_div: pipelined signed divider, one quotient bit per stage, truncation toward zero
// depends on nothing but its parameters
`timescale 1ns / 1ps
module cau_div #(
   parameter int NUM_WIDTH = 41,
   parameter int DEN_WIDTH = 32,
   parameter int TAG_WIDTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [NUM_WIDTH-1:0] in_num,
   input  logic        [DEN_WIDTH-1:0] in_den,
   input  logic        [TAG_WIDTH-1:0] in_tag,
   output logic                        out_valid,
   output logic signed [NUM_WIDTH-1:0] out_quo,
   output logic        [TAG_WIDTH-1:0] out_tag
);

   localparam int N = NUM_WIDTH;

   // per stage: remainder, quotient/dividend shift word, divisor, sign, tag
   logic [N:0]           vld_ff;
   logic [DEN_WIDTH-1:0] rem_ff [N+1];
   logic [N-1:0]         quo_ff [N+1];
   logic [DEN_WIDTH-1:0] den_ff [N+1];
   logic [N:0]           neg_ff;
   logic [TAG_WIDTH-1:0] tag_ff [N+1];
   logic [N-1:0]         mag_in;
   logic [DEN_WIDTH:0]   trial_in [N];
   logic [DEN_WIDTH+1:0] diff_in  [N];

   assign mag_in = in_num[N-1] ? N'(-in_num) : N'(in_num);

   // trial subtract of every step
   always_comb begin
      for (int s = 0; s < N; s++) begin
         trial_in[s] = {rem_ff[s], quo_ff[s][N-1]};
         diff_in[s]  = {1'b0, trial_in[s]} - {2'b0, den_ff[s]};
      end
   end

   // stage 0 load, then restoring steps
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[N-1:0], in_valid};
      rem_ff[0] <= '0;
      quo_ff[0] <= mag_in;
      den_ff[0] <= in_den;
      neg_ff[0] <= in_num[N-1];
      tag_ff[0] <= in_tag;
      for (int s = 0; s < N; s++) begin
         if (!diff_in[s][DEN_WIDTH+1]) begin
            rem_ff[s+1] <= diff_in[s][DEN_WIDTH-1:0];
            quo_ff[s+1] <= {quo_ff[s][N-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= trial_in[s][DEN_WIDTH-1:0];
            quo_ff[s+1] <= {quo_ff[s][N-2:0], 1'b0};
         end
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign out_valid = vld_ff[N];
   assign out_quo   = neg_ff[N] ? -$signed(quo_ff[N]) : $signed(quo_ff[N]);
   assign out_tag   = tag_ff[N];

endmodule

@@ hw/rtl/complex_arithmetic_unit_core.sv @@
// complex_arithmetic_unit_core: pipelined complex add, subtract, multiply and divide
// depends on cau_pkg and cau_div
`timescale 1ns / 1ps
// Usage
//   req channel: drive req_word and raise start; the word is taken on any
//   edge with start high (busy is tied low, a word may enter every cycle).
//   rsp channel: rsp_valid marks one cycle holding rsp_word; the receiver
//   cannot stall, results leave in order of arrival.
//   Stages: operand register, products, sums and scaling, then the
//   quotient pipeline of one bit per stage, then saturation and output.
//   Latency is the same for all kinds and is set by the divider pipeline;
//   non-divide results pass a matching delay line.
//   Throughput is one word per cycle.
//   Synchronous reset clears all valid bits; words in flight are dropped.
//   Nothing is kept between words.
module complex_arithmetic_unit_core
   import cau_pkg::*;
#(
   parameter int FRAC_BITS  = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int DATA_WIDTH = DataWidth;
   localparam int PW = 2 * DATA_WIDTH + 1;         // products sums
   localparam int NW = PW + FRAC_BITS;             // scaled numerator
   localparam int SW = NW + 1;                     // common result width
   localparam int TW = 2;

   assign busy = 1'b0;

   // stage 1: operands
   logic                         v1_ff;
   logic [1:0]                   k1_ff;
   logic signed [DATA_WIDTH-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      k1_ff  <= req_word.kind;
      ar1_ff <= DATA_WIDTH'(req_word.a_re);
      ai1_ff <= DATA_WIDTH'(req_word.a_im);
      br1_ff <= DATA_WIDTH'(req_word.b_re);
      bi1_ff <= DATA_WIDTH'(req_word.b_im);
   end

   // stage 2: the six products plus add/sub results
   logic                         v2_ff;
   logic [1:0]                   k2_ff;
   logic signed [2*DATA_WIDTH-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [DATA_WIDTH:0]   sre2_ff, sim2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      k2_ff   <= k1_ff;
      p_rr_ff <= ar1_ff * br1_ff;
      p_ii_ff <= ai1_ff * bi1_ff;
      p_ri_ff <= ar1_ff * bi1_ff;
      p_ir_ff <= ai1_ff * br1_ff;
      p_bb_ff <= br1_ff * br1_ff;
      p_cc_ff <= bi1_ff * bi1_ff;
      if (k1_ff == KIND_ADD) begin
         sre2_ff <= (DATA_WIDTH+1)'(ar1_ff) + (DATA_WIDTH+1)'(br1_ff);
         sim2_ff <= (DATA_WIDTH+1)'(ai1_ff) + (DATA_WIDTH+1)'(bi1_ff);
      end else begin
         sre2_ff <= (DATA_WIDTH+1)'(ar1_ff) - (DATA_WIDTH+1)'(br1_ff);
         sim2_ff <= (DATA_WIDTH+1)'(ai1_ff) - (DATA_WIDTH+1)'(bi1_ff);
      end
   end

   // stage 3: sums of products, pre-divide result candidates
   logic                 v3_ff;
   logic [1:0]           k3_ff;
   logic signed [SW-1:0] re3_ff, im3_ff;
   logic signed [NW-1:0] nre3_ff, nim3_ff;
   logic [PW-2:0]        den3_ff;
   logic signed [PW-1:0] mre_in, mim_in, dre_in, dim_in;
   always_comb begin
      mre_in = PW'(p_rr_ff) - PW'(p_ii_ff);
      mim_in = PW'(p_ri_ff) + PW'(p_ir_ff);
      dre_in = PW'(p_rr_ff) + PW'(p_ii_ff);
      dim_in = PW'(p_ir_ff) - PW'(p_ri_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      k3_ff   <= k2_ff;
      nre3_ff <= NW'(dre_in) <<< FRAC_BITS;
      nim3_ff <= NW'(dim_in) <<< FRAC_BITS;
      den3_ff <= (PW-1)'({1'b0, p_bb_ff} + {1'b0, p_cc_ff});
      case (k2_ff)
         KIND_MUL: begin
            re3_ff <= SW'(mre_in >>> FRAC_BITS);
            im3_ff <= SW'(mim_in >>> FRAC_BITS);
         end
         default: begin
            re3_ff <= SW'(sre2_ff);
            im3_ff <= SW'(sim2_ff);
         end
      endcase
   end

   // quotient pipelines, tag carries kind
   logic                 qv_re, qv_im;
   logic signed [NW-1:0] q_re, q_im;
   logic [TW-1:0]        qt_re, qt_im;
   cau_div #(.NUM_WIDTH(NW), .DEN_WIDTH(PW-1), .TAG_WIDTH(TW)) u_div_re (
      .clock(clock), .reset(reset), .in_valid(v3_ff), .in_num(nre3_ff),
      .in_den(den3_ff), .in_tag(k3_ff),
      .out_valid(qv_re), .out_quo(q_re), .out_tag(qt_re)
   );
   cau_div #(.NUM_WIDTH(NW), .DEN_WIDTH(PW-1), .TAG_WIDTH(TW)) u_div_im (
      .clock(clock), .reset(reset), .in_valid(v3_ff), .in_num(nim3_ff),
      .in_den(den3_ff), .in_tag(k3_ff),
      .out_valid(qv_im), .out_quo(q_im), .out_tag(qt_im)
   );

   // delay line for non-divide results and zero-divisor flag
   localparam int DL = NW + 1;
   logic signed [SW-1:0] dre_ff [DL];
   logic signed [SW-1:0] dim_ff [DL];
   logic [DL-1:0]        dz_ff;
   always_ff @(posedge clock) begin
      dre_ff[0] <= re3_ff;
      dim_ff[0] <= im3_ff;
      dz_ff[0]  <= (den3_ff == '0);
      for (int i = 1; i < DL; i++) begin
         dre_ff[i] <= dre_ff[i-1];
         dim_ff[i] <= dim_ff[i-1];
         dz_ff[i]  <= dz_ff[i-1];
      end
   end

   // final stage: select, saturate, status
   localparam logic signed [SW-1:0] MaxVal = SW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
   localparam logic signed [SW-1:0] MinVal = -MaxVal - SW'(1);
   logic signed [SW-1:0] fre_in, fim_in;
   logic                 sat_re_in, sat_im_in;
   logic                 div_sel_in;
   rsp_word_type         out_in;
   always_comb begin
      div_sel_in = (qt_re == KIND_DIV) && (qt_im == KIND_DIV);
      if (div_sel_in) begin
         fre_in = SW'(q_re);
         fim_in = SW'(q_im);
      end else begin
         fre_in = dre_ff[DL-1];
         fim_in = dim_ff[DL-1];
      end
      sat_re_in = (fre_in > MaxVal) || (fre_in < MinVal);
      sat_im_in = (fim_in > MaxVal) || (fim_in < MinVal);
      out_in = '0;
      if (div_sel_in && dz_ff[DL-1]) begin
         out_in.status = STAT_DBZ;
      end else begin
         out_in.res_re = sat_re_in ? (fre_in > MaxVal ? DATA_WIDTH'(MaxVal) : DATA_WIDTH'(MinVal))
                                   : DATA_WIDTH'(fre_in);
         out_in.res_im = sat_im_in ? (fim_in > MaxVal ? DATA_WIDTH'(MaxVal) : DATA_WIDTH'(MinVal))
                                   : DATA_WIDTH'(fim_in);
         out_in.status = (sat_re_in || sat_im_in) ? STAT_SAT : STAT_OK;
      end
   end

   logic         rv_ff;
   rsp_word_type rw_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else rv_ff <= qv_re & qv_im;
      rw_ff <= out_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_word  = rw_ff;

endmodule

@@ hw/rtl/cau_checker.sv @@
// cau_checker: port-level assertions for the complex arithmetic unit
// depends on cau_pkg and complex_arithmetic_unit_core
`timescale 1ns / 1ps
module cau_port_checker
   import cau_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_valid,
   input rsp_word_type rsp_word
);

   // unit never back-pressures
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // status stays within its codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status == STAT_OK || rsp_word.status == STAT_SAT ||
                     rsp_word.status == STAT_DBZ))
      else $error("bad status");

   // divide by zero carries zero result
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STAT_DBZ |-> rsp_word.res_re == '0 &&
      rsp_word.res_im == '0)
      else $error("nonzero result on divide by zero");

   // no response in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind complex_arithmetic_unit_core cau_port_checker u_cau_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
);
